// ===== rtl/core/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int NUM_W  = 2 * OPERAND_WIDTH + 1;
    localparam int DEN_W  = 2 * OPERAND_WIDTH;
    localparam int MUL_W  = OPERAND_WIDTH + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CNT_W  = $clog2(DEN_W + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_DEN_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]                      opcode;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic [OPERAND_WIDTH-1:0]        a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic [OPERAND_WIDTH-1:0]        b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic [1:0]              status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_FORM,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/rau_mul.sv =====
// Registered signed multiplier shared by the three cross products.
module rau_mul import rau_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/rau_gcd.sv =====
// Binary GCD engine: one shift or one compare-and-subtract per cycle.
module rau_gcd import rau_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEN_W-1:0] i_x,
    input  logic [DEN_W-1:0] i_y,
    output logic             o_done,
    output logic [DEN_W-1:0] o_g
);

    logic             r_run;
    logic             r_done;
    logic [DEN_W-1:0] r_x;
    logic [DEN_W-1:0] r_y;
    logic [DEN_W-1:0] r_g;
    logic [CNT_W-1:0] r_k;
    logic [DEN_W:0]   w_sub;
    logic             w_borrow;
    logic [DEN_W-1:0] w_diff;

    assign w_sub    = {1'b0, r_x} - {1'b0, r_y};
    assign w_borrow = w_sub[DEN_W];
    assign w_diff   = w_sub[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && (r_x == '0)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_k <= '0;
        end else if (r_run) begin
            if (r_x == '0) begin
                // restore the common power of two
                r_g <= r_y << r_k;
            end else if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + 1'b1;
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (!w_borrow) begin
                r_x <= w_diff;
            end else begin
                r_y <= '0 - w_diff;
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

// ===== rtl/core/rau_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rau_div import rau_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEN_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DEN_W-1:0] o_quot
);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_q;
    logic [DEN_W-1:0] r_d;
    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W+1:0] w_trial;
    logic             w_borrow;

    assign w_rem_sh = {r_rem, r_q[DEN_W-1]};
    assign w_trial  = {1'b0, w_rem_sh} - {2'b00, r_d};
    assign w_borrow = w_trial[DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(DEN_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_borrow ? w_rem_sh[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_q   <= {r_q[DEN_W-2:0], !w_borrow};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/core/rational_arith_unit.sv =====
// Rational add/subtract/multiply/divide with reduction to lowest terms.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+-------------------------------------------
//  command  | i_cmd (t_in_item)     | taken on the edge where start & !busy
//  result   | o_res (t_out_item)    | o_valid high one cycle, no back-pressure
//
// Steps: three products on one shared multiplier, a binary GCD with one shift or
// subtract per cycle, then two restoring divisions of the magnitude and of the
// denominator by the GCD. Error items go straight to the result state, and zero
// results skip the GCD and both divisions. busy stays high from acceptance to
// the result cycle.
// Reset is synchronous and active low and leaves the unit idle.
module rational_arith_unit import rau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_cmd,
    output logic      o_valid,
    output t_out_item o_res
);

    t_state    r_state;
    t_state    n_state;
    t_in_item  r_cmd;
    t_out_item r_out;

    logic signed [PROD_W-1:0] r_m0;
    logic signed [PROD_W-1:0] r_m1;
    logic signed [PROD_W-1:0] w_p;
    logic                     r_neg;
    logic [DEN_W-1:0]         r_mag;
    logic [DEN_W-1:0]         r_den;
    logic [DEN_W-1:0]         r_g;
    logic [DEN_W-1:0]         r_qn;

    logic                     w_accept;
    logic                     w_den_zero;
    logic                     w_div_zero;
    logic signed [MUL_W-1:0]  w_an;
    logic signed [MUL_W-1:0]  w_ad;
    logic signed [MUL_W-1:0]  w_bn;
    logic signed [MUL_W-1:0]  w_bd;
    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_num_s;
    logic signed [PROD_W-1:0] w_den_s;
    logic signed [PROD_W-1:0] w_mag_s;
    logic                     w_neg;
    logic [DEN_W-1:0]         w_mag;
    logic [DEN_W-1:0]         w_den;
    logic                     w_gcd_start;
    logic                     w_gcd_done;
    logic [DEN_W-1:0]         w_gcd_g;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [DEN_W-1:0]         w_div_q;
    logic [DEN_W-1:0]         w_div_dvd;
    logic [DEN_W-1:0]         w_div_dvs;
    logic [NUM_W-1:0]         w_qn_ext;

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_den_zero = (i_cmd.a_den == '0) || (i_cmd.b_den == '0);
    assign w_div_zero = (i_cmd.opcode == OP_DIV) && (i_cmd.b_num == '0);

    // operand extension to the multiplier width
    assign w_an = MUL_W'($signed(r_cmd.a_num));
    assign w_bn = MUL_W'($signed(r_cmd.b_num));
    assign w_ad = $signed({1'b0, r_cmd.a_den});
    assign w_bd = $signed({1'b0, r_cmd.b_den});

    rau_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_p)
    );

    // combine products; a negative divisor moves its sign to the numerator
    always_comb begin
        case (r_cmd.opcode)
            OP_ADD:  w_num_s = r_m0 + r_m1;
            OP_SUB:  w_num_s = r_m0 - r_m1;
            default: w_num_s = r_m0;
        endcase
        w_den_s = w_p;
        if ((r_cmd.opcode == OP_DIV) && w_p[PROD_W-1]) begin
            w_num_s = -w_num_s;
            w_den_s = -w_p;
        end
        w_neg   = w_num_s[PROD_W-1];
        w_mag_s = w_neg ? -w_num_s : w_num_s;
        w_mag   = w_mag_s[DEN_W-1:0];
        w_den   = w_den_s[DEN_W-1:0];
    end

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_x     (w_mag),
        .i_y     (w_den),
        .o_done  (w_gcd_done),
        .o_g     (w_gcd_g)
    );

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (w_den_zero || w_div_zero) ? S_DONE : S_MUL0;
                end
            end
            S_MUL0: n_state = S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_FORM;
            S_FORM: n_state = (w_mag == '0) ? S_DONE : S_GCD;
            S_GCD: begin
                if (w_gcd_done) begin
                    n_state = S_DIVN;
                end
            end
            S_DIVN: begin
                if (w_div_done) begin
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy        = (r_state != S_IDLE);
        o_valid     = (r_state == S_DONE);
        w_mul_a     = w_ad;
        w_mul_b     = w_bd;
        w_gcd_start = 1'b0;
        w_div_start = 1'b0;
        w_div_dvd   = r_mag;
        w_div_dvs   = r_g;
        case (r_state)
            S_MUL0: begin
                w_mul_a = w_an;
                w_mul_b = (r_cmd.opcode == OP_MUL) ? w_bn : w_bd;
            end
            S_MUL1: begin
                w_mul_a = w_ad;
                w_mul_b = w_bn;
            end
            S_MUL2: begin
                w_mul_a = w_ad;
                w_mul_b = (r_cmd.opcode == OP_DIV) ? w_bn : w_bd;
            end
            S_FORM: begin
                w_gcd_start = (w_mag != '0);
            end
            S_GCD: begin
                w_div_start = w_gcd_done;
                w_div_dvs   = w_gcd_g;
            end
            S_DIVN: begin
                w_div_start = w_div_done;
                w_div_dvd   = r_den;
            end
            default: begin
            end
        endcase
    end

    assign w_qn_ext = {1'b0, r_qn};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            if (w_den_zero) begin
                r_out <= '{res_num: '0, res_den: '0, status: ST_DEN_ZERO};
            end else if (w_div_zero) begin
                r_out <= '{res_num: '0, res_den: '0, status: ST_DIV_ZERO};
            end
        end
        if (r_state == S_MUL1) begin
            r_m0 <= w_p;
        end
        if (r_state == S_MUL2) begin
            r_m1 <= w_p;
        end
        if (r_state == S_FORM) begin
            r_neg <= w_neg;
            r_mag <= w_mag;
            r_den <= w_den;
            if (w_mag == '0) begin
                r_out <= '{res_num: '0, res_den: DEN_W'(1), status: ST_OK};
            end
        end
        if ((r_state == S_GCD) && w_gcd_done) begin
            r_g <= w_gcd_g;
        end
        if ((r_state == S_DIVN) && w_div_done) begin
            r_qn <= w_div_q;
        end
        if ((r_state == S_DIVD) && w_div_done) begin
            r_out.res_num <= r_neg ? $signed(~w_qn_ext + 1'b1) : $signed(w_qn_ext);
            r_out.res_den <= w_div_q;
            r_out.status  <= ST_OK;
        end
    end

    assign o_res = r_out;

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("unit not idle after result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_ok_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == ST_OK)) |-> (o_res.res_den != '0))
        else $error("ok result with zero denominator");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status != ST_OK)) |->
            ((o_res.res_num == '0) && (o_res.res_den == '0)))
        else $error("error result with nonzero fields");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_GCD) && w_gcd_done) |-> (w_gcd_g != '0))
        else $error("zero gcd");

endmodule

// ===== tb/rational_arith_unit_test.sv =====
// Self-checking testbench for the rational arithmetic unit: predicts each reduced fraction.
module rational_arith_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int NUM_MIN          = -(1 << (OPERAND_WIDTH - 1));
    localparam int NUM_MAX          = (1 << (OPERAND_WIDTH - 1)) - 1;
    localparam int DEN_MAX          = (1 << OPERAND_WIDTH) - 1;
    localparam int RANDOM_PER_PHASE = 578;
    localparam int TAIL_CYCLES      = 300;
    localparam int QUIET_LIMIT      = 5000;

    class fraction_book;
        t_out_item   owed_fractions[$];
        int unsigned mismatches;

        function t_out_item exact_fraction(t_in_item cmd);
            longint            an, ad, bn, bd, num, den;
            longint unsigned   mag, x, y, r;
            t_out_item         res;
            an  = cmd.a_num;
            ad  = cmd.a_den;
            bn  = cmd.b_num;
            bd  = cmd.b_den;
            res = '0;
            // a zero denominator wins over the divide check
            if (ad == 0 || bd == 0) begin
                res.status = ST_DEN_ZERO;
                return res;
            end
            case (cmd.opcode)
                OP_ADD: begin
                    num = an * bd + ad * bn;
                    den = ad * bd;
                end
                OP_SUB: begin
                    num = an * bd - ad * bn;
                    den = ad * bd;
                end
                OP_MUL: begin
                    num = an * bn;
                    den = ad * bd;
                end
                OP_DIV: begin
                    if (bn == 0) begin
                        res.status = ST_DIV_ZERO;
                        return res;
                    end
                    num = an * bd;
                    den = ad * bn;
                    // move the divisor's sign to the numerator
                    if (den < 0) begin
                        den = -den;
                        num = -num;
                    end
                end
                default: begin
                    num = 0;
                    den = 1;
                end
            endcase
            mag = (num < 0) ? longint'(-num) : num;
            x   = mag;
            y   = den;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            if (x == 0)
                x = 1;
            mag = mag / x;
            den = longint'(longint'(den) / x);
            num = (num < 0) ? -longint'(mag) : longint'(mag);
            if (num == 0)
                den = 1;
            res.res_num = num[NUM_W-1:0];
            res.res_den = den[DEN_W-1:0];
            res.status  = ST_OK;
            return res;
        endfunction

        function void note_command(t_in_item cmd);
            owed_fractions.push_back(exact_fraction(cmd));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed_fractions.size() == 0) begin
                $display("%0t: unexpected result %0d/%0d status %0d", $time,
                         got.res_num, got.res_den, got.status);
                mismatches++;
                return;
            end
            want = owed_fractions.pop_front();
            if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
                got.status !== want.status) begin
                $display("%0t: mismatch expected %0d/%0d status %0d, actual %0d/%0d status %0d",
                         $time, want.res_num, want.res_den, want.status,
                         got.res_num, got.res_den, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        o_valid;
    t_in_item    i_cmd;
    t_out_item   o_res;
    int unsigned send_idle_pct;
    int unsigned quiet_cycles = 0;

    fraction_book book = new();

    rational_arith_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                book.note_command(i_cmd);
            if (o_valid)
                book.check_result(o_res);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [OPERAND_WIDTH-1:0] pick_num();
        logic [OPERAND_WIDTH-1:0] v;
        case ($urandom_range(9))
            0:       v = OPERAND_WIDTH'(NUM_MIN);
            1:       v = OPERAND_WIDTH'(NUM_MAX);
            2, 3:    v = OPERAND_WIDTH'($urandom_range(0, 24));
            // products of small factors give deep reductions
            4:       v = OPERAND_WIDTH'($urandom_range(1, 180) * $urandom_range(0, 180));
            default: v = OPERAND_WIDTH'($urandom);
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    function automatic logic [OPERAND_WIDTH-1:0] pick_den();
        logic [OPERAND_WIDTH-1:0] v;
        case ($urandom_range(24))
            0:       v = '0;
            1:       v = '1;
            2, 3, 4: v = OPERAND_WIDTH'($urandom_range(1, 24));
            5, 6, 7: v = OPERAND_WIDTH'($urandom_range(1, 180) * $urandom_range(1, 360));
            default: v = OPERAND_WIDTH'($urandom);
        endcase
        return v;
    endfunction

    function automatic t_in_item random_command();
        t_in_item c;
        c.opcode = 2'($urandom_range(3));
        c.a_num  = pick_num();
        c.a_den  = pick_den();
        c.b_num  = pick_num();
        c.b_den  = pick_den();
        return c;
    endfunction

    function automatic t_in_item make_cmd(logic [1:0] op, int an, int ad, int bn, int bd);
        t_in_item c;
        c.opcode = op;
        c.a_num  = an[OPERAND_WIDTH-1:0];
        c.a_den  = ad[OPERAND_WIDTH-1:0];
        c.b_num  = bn[OPERAND_WIDTH-1:0];
        c.b_den  = bd[OPERAND_WIDTH-1:0];
        return c;
    endfunction

    task automatic send_command(input t_in_item cmd);
        int unsigned gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 250);
            start <= 1'b0;
            // drive noise on the command bus while start is low
            repeat (gap) begin
                i_cmd <= random_command();
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_cmd <= cmd;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge i_clk);
        while (book.owed_fractions.size() != 0);
    endtask

    initial begin
        start         <= 1'b0;
        i_cmd         <= '0;
        i_rst_n       <= 1'b0;
        send_idle_pct = 29;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_command(make_cmd(OP_ADD, 1, 2, 1, 3));
        send_command(make_cmd(OP_SUB, 3, 4, 3, 4));
        send_command(make_cmd(OP_MUL, NUM_MIN, 1, NUM_MIN, 1));
        send_command(make_cmd(OP_MUL, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX));
        send_command(make_cmd(OP_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX));
        send_command(make_cmd(OP_SUB, NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX - 1));
        send_command(make_cmd(OP_DIV, 1, 2, -1, 3));
        send_command(make_cmd(OP_DIV, -5, 6, -10, 9));
        send_command(make_cmd(OP_DIV, NUM_MIN, 1, -1, 1));
        send_command(make_cmd(OP_DIV, NUM_MAX, DEN_MAX, NUM_MIN, 1));
        send_command(make_cmd(OP_DIV, 7, 3, 0, 5));
        send_command(make_cmd(OP_ADD, 4, 0, 3, 5));
        send_command(make_cmd(OP_MUL, 4, 7, 3, 0));
        send_command(make_cmd(OP_DIV, 2, 0, 0, 0));
        send_command(make_cmd(OP_DIV, NUM_MAX, 0, 0, DEN_MAX));
        send_command(make_cmd(OP_MUL, 0, 7, -9, 4));
        send_command(make_cmd(OP_SUB, 0, 1, 0, DEN_MAX));
        send_command(make_cmd(OP_ADD, -1, DEN_MAX, 1, DEN_MAX));
        send_command(make_cmd(OP_MUL, -6, 4, 10, 15));

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 59 : 0;
            repeat (RANDOM_PER_PHASE) send_command(random_command());
            // hold off until every pending result is back
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.mismatches == 0 && book.owed_fractions.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== rational_arith_unit.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_mul.sv
rtl/core/rau_gcd.sv
rtl/core/rau_div.sv
rtl/core/rational_arith_unit.sv
tb/rational_arith_unit_test.sv
